[hdl/bucketed_cuckoo_table_store_unit_assert.svh]
// assertion macros for the bucketed cuckoo table store
`ifndef BUCKETED_CUCKOO_TABLE_STORE_UNIT_ASSERT_SVH
`define BUCKETED_CUCKOO_TABLE_STORE_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define BCTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define BCTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bcts_pkg.sv]
// types and constants of the bucketed cuckoo table store
package bcts_pkg;

  localparam int MAX_ROWS_DEF = 1024;
  localparam int SLOTS_DEF    = 8;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int ROW_FW  = 10;
  localparam int SLOT_FW = 3;
  localparam int FILL_W  = 14;

  localparam int ROWS_CFG_W  = 11;
  localparam int SLOTS_CFG_W = 4;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_ADDR_W  = 1;

  // widened forms used for range checks and the capacity product
  localparam int ROWX_W  = 17;
  localparam int SLOTX_W = 5;
  localparam int CAP_W   = ROWX_W + SLOTX_W;

  localparam int FILL_MAX = (1 << FILL_W) - 1;

  localparam logic [ROWS_CFG_W-1:0]  ROWS_RST  = 11'd1024;
  localparam logic [SLOTS_CFG_W-1:0] SLOTS_RST = 4'd8;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ROWS_IN_USE   = 1'b0,
    CFG_SLOTS_PER_ROW = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW_A,
    ST_ROW_B
  } state_e;

  typedef struct packed {
    mode_e               mode;
    logic [ROW_FW-1:0]   row_a;
    logic [ROW_FW-1:0]   row_b;
    logic [SLOT_FW-1:0]  slot;
    logic [KEY_W-1:0]    entry_key;
    logic [VAL_W-1:0]    entry_value;
  } item_t;

  // what the first candidate row of a lookup left behind
  typedef struct packed {
    logic               found;
    logic [SLOT_FW-1:0] found_slot;
    logic               has_empty;
    logic [SLOT_FW-1:0] empty_slot;
  } look_a_t;

  typedef struct packed {
    logic               status;
    logic               found;
    logic [ROW_FW-1:0]  found_row;
    logic [SLOT_FW-1:0] found_slot;
    logic               a_has_empty;
    logic [SLOT_FW-1:0] a_empty_slot;
    logic               b_has_empty;
    logic [SLOT_FW-1:0] b_empty_slot;
    logic [FILL_W-1:0]  fill_count;
    logic               table_full;
  } result_t;

endpackage

[hdl/bucketed_cuckoo_table_store_unit.sv]
// bucketed cuckoo table store: row memory, write and two-row lookup sequencer
// a write or a rejected lookup ends in ST_ROW_A, a valid lookup goes on to ST_ROW_B;
// a new item is taken only in ST_IDLE when the result word is free or being read; each
// row visit reads the single-port row memory once, all slots compared at once, and a
// write then puts the row back; reset: config goes to 1024 rows and 8 slots, then a
// clearing pass writes every row to zero, with s_axis_tready_o low
module bucketed_cuckoo_table_store_unit
  import bcts_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int SLOTS    = SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // row_a, row_b, slot, entry_key, entry_value, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // mode
  input  logic                   s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // found, found_row, found_slot, a_has_empty, a_empty_slot, b_has_empty,
  // b_empty_slot, fill_count, table_full, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status
  output logic                   m_axis_tuser_o
);

  localparam int RA_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(MAX_ROWS * SLOTS + 1);

  typedef struct packed {
    logic [SLOTS-1:0][VAL_W-1:0] vals;
    logic [SLOTS-1:0][KEY_W-1:0] keys;
  } row_t;

  function automatic logic [RA_W-1:0] row_addr(logic [ROW_FW-1:0] r);
    logic [ROWX_W-1:0] w;
    w = ROWX_W'(r);
    return w[RA_W-1:0];
  endfunction

  function automatic logic [SLOT_FW-1:0] slot_field(logic [SLOT_IW-1:0] s);
    logic [SLOTX_W-1:0] w;
    w = SLOTX_W'(s);
    return w[SLOT_FW-1:0];
  endfunction

  // lowest set bit: {any, index}
  function automatic logic [SLOT_IW:0] first_hit(logic [SLOTS-1:0] hit);
    logic [SLOT_IW:0] r;
    r = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (hit[s]) begin
        r = {1'b1, SLOT_IW'(s)};
      end
    end
    return r;
  endfunction

  state_e                 state_q, state_d;
  logic [ROWS_CFG_W-1:0]  rows_q;
  logic [SLOTS_CFG_W-1:0] slots_q;
  logic [RA_W-1:0]        clr_q, clr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  item_t                  item_q, in_item;
  look_a_t                look_a_q, look_a_d;
  result_t                res_q, res_d;
  logic                   out_valid_q;

  row_t                   mem_q [MAX_ROWS];
  row_t                   rd_q;
  row_t                   wd;
  logic                   rd_en, mem_we;
  logic [RA_W-1:0]        rd_addr, wa;

  logic                   in_acc, res_load;
  logic [ROWX_W-1:0]      eff_rows, rows_x;
  logic [SLOTX_W-1:0]     eff_slots, slots_x;
  logic [CAP_W-1:0]       capacity, cnt_ext;
  logic                   err_a, err_b, err_slot, wr_err, lk_err;
  logic [SLOTS-1:0]       hit_key, hit_empty;
  logic [SLOT_IW:0]       key_pick, empty_pick;
  logic [SLOT_IW-1:0]     wr_idx;
  logic [SLOTX_W-1:0]     slot_x;
  logic                   old_empty;
  row_t                   wr_row;

  assign in_item.mode        = mode_e'(s_axis_tuser_i);
  assign in_item.row_a       = s_axis_tdata_i[9:0];
  assign in_item.row_b       = s_axis_tdata_i[19:10];
  assign in_item.slot        = s_axis_tdata_i[22:20];
  assign in_item.entry_key   = s_axis_tdata_i[54:23];
  assign in_item.entry_value = s_axis_tdata_i[86:55];

  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;

  // register values clamped to between 1 and the table size
  always_comb begin
    rows_x  = ROWX_W'(rows_q);
    slots_x = SLOTX_W'(slots_q);
    if (rows_x == '0) begin
      eff_rows = ROWX_W'(1);
    end else if (rows_x > ROWX_W'(MAX_ROWS)) begin
      eff_rows = ROWX_W'(MAX_ROWS);
    end else begin
      eff_rows = rows_x;
    end
    if (slots_x == '0) begin
      eff_slots = SLOTX_W'(1);
    end else if (slots_x > SLOTX_W'(SLOTS)) begin
      eff_slots = SLOTX_W'(SLOTS);
    end else begin
      eff_slots = slots_x;
    end
  end

  assign capacity = CAP_W'(eff_rows) * CAP_W'(eff_slots);

  assign err_a    = ROWX_W'(item_q.row_a) >= eff_rows;
  assign err_b    = ROWX_W'(item_q.row_b) >= eff_rows;
  assign err_slot = SLOTX_W'(item_q.slot) >= eff_slots;
  assign wr_err   = err_a | err_slot;
  assign lk_err   = err_a | err_b;

  // all slots of the row just read compared at once
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      hit_key[s]   = (SLOTX_W'(s) < eff_slots) && (rd_q.keys[s] == item_q.entry_key);
      hit_empty[s] = (SLOTX_W'(s) < eff_slots) && (rd_q.keys[s] == '0);
    end
  end

  assign key_pick   = first_hit(hit_key);
  assign empty_pick = first_hit(hit_empty);

  assign slot_x    = SLOTX_W'(item_q.slot);
  assign wr_idx    = slot_x[SLOT_IW-1:0];
  assign old_empty = rd_q.keys[wr_idx] == '0;

  always_comb begin
    wr_row              = rd_q;
    wr_row.keys[wr_idx] = item_q.entry_key;
    wr_row.vals[wr_idx] = item_q.entry_value;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == RA_W'(MAX_ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_ROW_A;
        end
      end
      ST_ROW_A: begin
        if (item_q.mode == MODE_LOOKUP && !lk_err) begin
          state_d = ST_ROW_B;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ROW_B: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs, memory port control and result assembly
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = row_addr(item_q.row_b);
    mem_we          = 1'b0;
    wa              = clr_q;
    wd              = '0;
    res_load        = 1'b0;
    res_d           = '0;
    cnt_d           = cnt_q;
    look_a_d        = look_a_q;
    clr_d           = clr_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + RA_W'(1);
      end
      ST_IDLE: begin
        s_axis_tready_o = !out_valid_q || m_axis_tready_i;
        if (in_acc) begin
          rd_en   = 1'b1;
          rd_addr = row_addr(in_item.row_a);
        end
      end
      ST_ROW_A: begin
        if (item_q.mode == MODE_WRITE) begin
          res_load = 1'b1;
          if (wr_err) begin
            res_d.status = 1'b1;
          end else begin
            mem_we = 1'b1;
            wa     = row_addr(item_q.row_a);
            wd     = wr_row;
            cnt_d  = cnt_q + CNT_W'(old_empty) - CNT_W'(item_q.entry_key == '0);
          end
        end else if (lk_err) begin
          res_load     = 1'b1;
          res_d.status = 1'b1;
        end else begin
          look_a_d.found      = key_pick[SLOT_IW];
          look_a_d.found_slot = slot_field(key_pick[SLOT_IW-1:0]);
          look_a_d.has_empty  = empty_pick[SLOT_IW];
          look_a_d.empty_slot = slot_field(empty_pick[SLOT_IW-1:0]);
          rd_en   = 1'b1;
          rd_addr = row_addr(item_q.row_b);
        end
      end
      ST_ROW_B: begin
        res_load = 1'b1;
        if (look_a_q.found) begin
          res_d.found      = 1'b1;
          res_d.found_row  = item_q.row_a;
          res_d.found_slot = look_a_q.found_slot;
        end else if (key_pick[SLOT_IW]) begin
          res_d.found      = 1'b1;
          res_d.found_row  = item_q.row_b;
          res_d.found_slot = slot_field(key_pick[SLOT_IW-1:0]);
        end
        res_d.a_has_empty  = look_a_q.has_empty;
        res_d.a_empty_slot = look_a_q.empty_slot;
        res_d.b_has_empty  = empty_pick[SLOT_IW];
        res_d.b_empty_slot = slot_field(empty_pick[SLOT_IW-1:0]);
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
    cnt_ext = CAP_W'(cnt_d);
    if (cnt_ext > CAP_W'(FILL_MAX)) begin
      res_d.fill_count = FILL_W'(FILL_MAX);
    end else begin
      res_d.fill_count = cnt_ext[FILL_W-1:0];
    end
    res_d.table_full = cnt_ext == capacity;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      rows_q      <= ROWS_RST;
      slots_q     <= SLOTS_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_ROWS_IN_USE:   rows_q  <= cfg_data_i[ROWS_CFG_W-1:0];
          CFG_SLOTS_PER_ROW: slots_q <= cfg_data_i[SLOTS_CFG_W-1:0];
          default:           rows_q  <= rows_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item;
    end
    look_a_q <= look_a_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // row memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.status;
  assign m_axis_tdata_o  = {3'b000, res_q.table_full, res_q.fill_count,
                            res_q.b_empty_slot, res_q.b_has_empty,
                            res_q.a_empty_slot, res_q.a_has_empty,
                            res_q.found_slot, res_q.found_row, res_q.found};

  `include "bucketed_cuckoo_table_store_unit_assert.svh"

  `BCTS_ASSERT_NOW(a_no_accept_in_clear, state_q == ST_CLEAR, !s_axis_tready_o, "accept during clear")
  `BCTS_ASSERT_NOW(a_write_state, mem_we, state_q == ST_CLEAR || state_q == ST_ROW_A, "stray row write")
  `BCTS_ASSERT_NOW(a_result_room, res_load, !out_valid_q || m_axis_tready_i, "result overwrites word")
  `BCTS_ASSERT_NOW(a_count_bound, 1'b1, CAP_W'(cnt_q) <= CAP_W'(MAX_ROWS * SLOTS), "count too high")
  `BCTS_ASSERT_NEXT(a_accept_reads_a, in_acc, state_q == ST_ROW_A, "accept not followed by row read")

endmodule
